@@ rtl/core/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial division prime test: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int CAND_BITS      = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SQRT,
        ST_CHECK,
        ST_DIV,
        ST_TEST,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic scan_init;
        logic div_init;
        logic div_step;
        logic next_d;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic lt2;
        logic two;
        logic even;
        logic sqrt_last;
        logic div_last;
        logic d_gt_root;
        logic rem_zero;
    } sts_t;

endpackage

@@ rtl/core/tdpt_datapath.sv @@
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate register, bit-serial integer square root (two bits a cycle) and
// bit-serial restoring remainder of the candidate by the trial divisor.
// ----------------------------------------------------------------------------
module tdpt_datapath
    import tdpt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic [CAND_BITS-1:0] candidate,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int RW = (VALUE_BITS + 1) / 2;
    localparam int NW = 2 * RW;
    localparam int CW = $clog2(NW + 1);

    logic [VALUE_BITS-1:0] n_reg;
    logic [NW-1:0]         sh_reg,   sh_next;
    logic [RW+1:0]         rem_reg,  rem_next;
    logic [RW-1:0]         root_reg, root_next;
    logic [RW:0]           div_reg,  div_next;
    logic [CW-1:0]         cnt_reg,  cnt_next;

    logic [RW+1:0] sq_sh;
    logic [RW+1:0] sq_trial;
    logic [RW+1:0] dv_sh;
    logic [RW+1:0] dv_den;

    assign sq_sh    = {rem_reg[RW-1:0], sh_reg[NW-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign dv_sh    = {rem_reg[RW:0], sh_reg[NW-1]};
    assign dv_den   = {1'b0, div_reg};

    always_comb begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        if (cmd.load) begin
            sh_next   = NW'(candidate[VALUE_BITS-1:0]);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
        end else if (cmd.sqrt_step) begin
            sh_next  = {sh_reg[NW-3:0], 2'b00};
            cnt_next = cnt_reg + CW'(1);
            if (sq_sh >= sq_trial) begin
                rem_next  = sq_sh - sq_trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = sq_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
        end else if (cmd.div_init) begin
            sh_next  = NW'(n_reg);
            rem_next = '0;
            cnt_next = '0;
        end else if (cmd.div_step) begin
            sh_next  = {sh_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg + CW'(1);
            if (dv_sh >= dv_den) begin
                rem_next = dv_sh - dv_den;
            end else begin
                rem_next = dv_sh;
            end
        end
        if (cmd.scan_init) begin
            div_next = (RW+1)'(3);
        end else if (cmd.next_d) begin
            div_next = div_reg + (RW+1)'(2);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg <= candidate[VALUE_BITS-1:0];
        end
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        div_reg  <= div_next;
        cnt_reg  <= cnt_next;
    end

    always_comb begin
        sts.neg       = n_reg[VALUE_BITS-1];
        sts.lt2       = (n_reg[VALUE_BITS-1:1] == '0);
        sts.two       = (n_reg == VALUE_BITS'(2));
        sts.even      = !n_reg[0];
        sts.sqrt_last = (cnt_reg == CW'(RW - 1));
        sts.div_last  = (cnt_reg == CW'(NW - 1));
        sts.d_gt_root = (div_reg > {1'b0, root_reg});
        sts.rem_zero  = (rem_reg == '0);
    end

endmodule

@@ rtl/core/tdpt_controller.sv @@
// ----------------------------------------------------------------------------
// tdpt_controller
// Sequencer of the prime test: screens trivial values, runs the square root,
// steps odd divisors up to the root and holds the verdict in the result
// register until it is taken.
// ----------------------------------------------------------------------------
module tdpt_controller
    import tdpt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output logic is_prime,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;
    logic   verdict_reg, verdict_next;
    logic   m_valid_reg, m_valid_next;
    logic   is_prime_reg;
    logic   push;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (sts.neg || sts.lt2 || sts.even) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sts.sqrt_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.d_gt_root) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sts.rem_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        push         = 1'b0;
        verdict_next = verdict_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_START: begin
                verdict_next = sts.two;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cmd.scan_init = sts.sqrt_last;
            end
            ST_CHECK: begin
                if (sts.d_gt_root) begin
                    verdict_next = 1'b1;
                end else begin
                    cmd.div_init = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_TEST: begin
                if (sts.rem_zero) begin
                    verdict_next = 1'b0;
                end else begin
                    cmd.next_d = 1'b1;
                end
            end
            ST_FINISH: begin
                push = slot_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        verdict_reg <= verdict_next;
        if (push) begin
            is_prime_reg <= verdict_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign is_prime = is_prime_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_START)
        else $error("accepted item did not start screening");

    a_div_to_test: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && sts.div_last |=> state_reg == ST_TEST)
        else $error("remainder pass did not end in test");

    a_push_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && slot_free
        |=> m_valid_reg && is_prime_reg == $past(verdict_reg))
        else $error("verdict not moved to result register");

    a_two_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_START && sts.two |=> verdict_reg && state_reg == ST_FINISH)
        else $error("two not reported prime");

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test of one signed candidate per item by odd trial division up
// to the integer square root.
// ----------------------------------------------------------------------------
// Only the low VALUE_BITS bits of s_candidate count, read as two's complement.
// Negative values, zero, one and all even values pass from acceptance through
// the screening state to the finish state, which loads the result register,
// and the block then returns to idle to accept the next item. Other values
// first run the bit-serial square root (R = (VALUE_BITS+1)/2 root bits),
// then for each odd divisor d from 3 up to the root a check state, a
// bit-serial remainder over the 2*R-bit shifted candidate and a test state,
// and for a prime a final check state and the finish state that loads the
// result register. All divisors use the single shared remainder unit. One
// item is in work at a time; a finished result waits in the output register
// while the next item is accepted, and the block stalls only when a second
// verdict is ready while the first one has not been taken.
// ----------------------------------------------------------------------------
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CAND_BITS-1:0] s_candidate,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_prime
);

    cmd_t cmd;
    sts_t sts;

    tdpt_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .is_prime (m_is_prime),
        .cmd      (cmd),
        .sts      (sts)
    );

    tdpt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .candidate (s_candidate),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
